// ===== rtl/nss_pkg.sv =====
// Shared constants, types and ROM functions of the note step sequencer.
package nss_pkg;

   localparam int StepDepth = 1024;
   localparam int StepBits = 10;
   localparam int MaxAdvance = 9;
   localparam int AdvBits = 4;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;
   localparam logic [1:0] OP_UPDATE = 2'd3;

   localparam logic [1:0] CSR_STEP_COUNT = 2'd0;
   localparam logic [1:0] CSR_ARP_ENABLE = 2'd1;
   localparam logic [1:0] CSR_ARP_VOICE = 2'd2;
   localparam logic [1:0] CSR_MASTER_VOLUME = 2'd3;

   localparam logic [15:0] WORD_IDLE = 16'hFFFF;
   localparam logic [15:0] WORD_ARP = 16'hFFFE;

   // One channel command.
   typedef struct packed {
      logic [2:0] channel;
      logic on;
      logic [10:0] freq;
      logic [3:0] level;
      logic last;
   } cmd_type;

   // Note number to frequency register value.
   function automatic logic [10:0] note_freq(input logic [6:0] note);
      logic [10:0] f;
      case (note)
         7'd40: f = 11'h02C; 7'd41: f = 11'h09C; 7'd42: f = 11'h106; 7'd43: f = 11'h16B;
         7'd44: f = 11'h1C9; 7'd45: f = 11'h223; 7'd46: f = 11'h277; 7'd47: f = 11'h2C6;
         7'd48: f = 11'h312; 7'd49: f = 11'h356; 7'd50: f = 11'h39B; 7'd51: f = 11'h3DA;
         7'd52: f = 11'h416; 7'd53: f = 11'h44E; 7'd54: f = 11'h483; 7'd55: f = 11'h4B5;
         7'd56: f = 11'h4E5; 7'd57: f = 11'h511; 7'd58: f = 11'h53B; 7'd59: f = 11'h563;
         7'd60: f = 11'h589; 7'd61: f = 11'h5AC; 7'd62: f = 11'h5CE; 7'd63: f = 11'h5ED;
         7'd64: f = 11'h60A; 7'd65: f = 11'h627; 7'd66: f = 11'h642; 7'd67: f = 11'h65B;
         7'd68: f = 11'h672; 7'd69: f = 11'h689; 7'd70: f = 11'h69E; 7'd71: f = 11'h6B2;
         7'd72: f = 11'h6C4; 7'd73: f = 11'h6D6; 7'd74: f = 11'h6E7; 7'd75: f = 11'h6F7;
         7'd76: f = 11'h706; 7'd77: f = 11'h714; 7'd78: f = 11'h721; 7'd79: f = 11'h72D;
         7'd80: f = 11'h739; 7'd81: f = 11'h744; 7'd82: f = 11'h74F; 7'd83: f = 11'h759;
         7'd84: f = 11'h762; 7'd85: f = 11'h76B; 7'd86: f = 11'h773; 7'd87: f = 11'h77B;
         7'd88: f = 11'h783; 7'd89: f = 11'h78A; 7'd90: f = 11'h790; 7'd91: f = 11'h797;
         7'd92: f = 11'h79D; 7'd93: f = 11'h7A2; 7'd94: f = 11'h7A7; 7'd95: f = 11'h7AC;
         7'd96: f = 11'h7B1; 7'd97: f = 11'h7B6; 7'd98: f = 11'h7BA; 7'd99: f = 11'h7BE;
         7'd100: f = 11'h7C1; 7'd101: f = 11'h7C4; 7'd102: f = 11'h7C8; 7'd103: f = 11'h7CB;
         7'd104: f = 11'h7CE; 7'd105: f = 11'h7D1; 7'd106: f = 11'h7D4; 7'd107: f = 11'h7D6;
         7'd108: f = 11'h7D9; 7'd109: f = 11'h7DB; 7'd110: f = 11'h7DD; 7'd111: f = 11'h7DF;
         default: f = 11'd0;
      endcase
      return f;
   endfunction

   // Velocity and clamped volume (0..4) to level, before the floor of one.
   function automatic logic [2:0] vel_level(input logic [3:0] vel, input logic [2:0] vol);
      logic [14:0] row;
      case (vel)
         4'd4: row = {3'd1, 3'd0, 3'd0, 3'd0, 3'd0};
         4'd5, 4'd6, 4'd7: row = {3'd1, 3'd1, 3'd0, 3'd0, 3'd0};
         4'd8, 4'd9: row = {3'd2, 3'd1, 3'd1, 3'd0, 3'd0};
         4'd10, 4'd11: row = {3'd2, 3'd2, 3'd1, 3'd0, 3'd0};
         4'd12, 4'd13, 4'd14: row = {3'd3, 3'd2, 3'd1, 3'd0, 3'd0};
         4'd15: row = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
         default: row = 15'd0;
      endcase
      case (vol)
         3'd0: return row[2:0];
         3'd1: return row[5:3];
         3'd2: return row[8:6];
         3'd3: return row[11:9];
         default: return row[14:12];
      endcase
   endfunction

endpackage

// ===== rtl/nss_step_mem.sv =====
// Step store: voice words, arpeggio byte and duration, one row per step.
module nss_step_mem (
   input logic clock,
   input logic wr_en,
   input logic [nss_pkg::StepBits-1:0] wr_addr,
   input logic [71:0] wr_data,
   input logic [nss_pkg::StepBits-1:0] rd_addr,
   output logic [71:0] rd_data
);
   logic [71:0] mem [nss_pkg::StepDepth];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/note_step_sequencer_with_arpeggio.sv =====
// Top level of the three-voice note step sequencer with arpeggio.
// Write, start: accepted back to back. Stop: four silences, one per cycle unless stalled.
// Update: phase multiplies, three voices, last flag, step check, then an advance, reread
//   and step check for each step advanced (up to 9); a stalled result holds it up.
// One transaction is in flight at a time; req_stall is high while it works.
// Synchronous reset clears control and config state (volume 3), not the step store.
module note_step_sequencer_with_arpeggio (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_op,
   input logic [9:0] req_step_index,
   input logic [15:0] req_melody_word,
   input logic [15:0] req_bass_word,
   input logic [15:0] req_chord_word,
   input logic [7:0] req_arp_offsets,
   input logic [15:0] req_step_time_ms,
   input logic [31:0] req_now_tick,
   input logic req_play_enable,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_sound_channel,
   output logic rsp_channel_on,
   output logic [10:0] rsp_frequency_code,
   output logic [3:0] rsp_level,
   output logic rsp_last,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [10:0] csr_write_data
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL = 4'd2;
   localparam logic [3:0] S_PH1 = 4'd3;
   localparam logic [3:0] S_VOICE = 4'd4;
   localparam logic [3:0] S_EMIT = 4'd5;
   localparam logic [3:0] S_ADV = 4'd6;
   localparam logic [3:0] S_AREAD = 4'd7;
   localparam logic [3:0] S_ACHK = 4'd8;
   localparam logic [3:0] S_STOP = 4'd9;

   logic [10:0] step_count_ff;
   logic arp_enable_ff;
   logic [1:0] arp_voice_ff;
   logic [2:0] master_volume_ff;

   logic [3:0] state_ff, state_in;
   logic [9:0] step_ff, step_in;
   logic [31:0] start_ff, start_in;
   logic running_ff, running_in;
   logic [15:0] lastw_ff [3];
   logic [15:0] lastw_in [3];
   logic [31:0] now_ff, now_in;
   logic [1:0] voice_ff, voice_in;
   logic [3:0] adv_ff, adv_in;
   logic [15:0] q_ff, q_in;
   logic [7:0] phase_ff, phase_in;
   logic [31:0] dur_ff, dur_in;
   logic [2:0] pend_ff, pend_in;
   logic [2:0] stopn_ff, stopn_in;
   nss_pkg::cmd_type cmd_ff, cmd_in;
   nss_pkg::cmd_type held_ff, held_in;
   logic out_valid_ff, out_valid_in;

   logic [71:0] rd_data;
   logic [9:0] rd_addr;
   logic mem_we;

   // Shared multiplier: 32x10 operands, selected by state
   logic [31:0] mul_a;
   logic [9:0] mul_b;
   logic [41:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [2:0] vol_c;
   logic [31:0] elapsed;
   logic [15:0] raw;
   logic [3:0] vel;
   logic [7:0] note_sum;
   logic [6:0] note;
   logic [10:0] freq;
   logic [2:0] lvl;
   logic is_arp;
   logic [2:0] vchan;
   logic [9:0] nxt_step;
   logic [15:0] arp_rearm [3];

   assign vol_c = (master_volume_ff > 3'd4) ? 3'd4 : master_volume_ff;
   assign elapsed = now_ff - start_ff;
   assign mem_we = req_valid && !req_stall && req_op == nss_pkg::OP_WRITE;

   nss_step_mem u_mem (
      .clock(clock),
      .wr_en(mem_we),
      .wr_addr(req_step_index),
      .wr_data({req_melody_word, req_bass_word, req_chord_word, req_arp_offsets,
                req_step_time_ms}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= 11'd0;
         arp_enable_ff <= 1'b0;
         arp_voice_ff <= 2'd0;
         master_volume_ff <= 3'd3;
      end else if (csr_write_enable) begin
         case (csr_index)
            nss_pkg::CSR_STEP_COUNT: step_count_ff <= csr_write_data;
            nss_pkg::CSR_ARP_ENABLE: arp_enable_ff <= csr_write_data[0];
            nss_pkg::CSR_ARP_VOICE: arp_voice_ff <= csr_write_data[1:0];
            default: master_volume_ff <= csr_write_data[2:0];
         endcase
      end
   end

   // Voice decode from the read row
   always_comb begin
      case (voice_ff)
         2'd0: raw = rd_data[71:56];
         2'd1: raw = rd_data[55:40];
         default: raw = rd_data[39:24];
      endcase
      vel = raw[15:12];
      is_arp = arp_enable_ff && voice_ff == arp_voice_ff;
      note_sum = {1'b0, raw[10:4]};
      if (is_arp && rd_data[23:16] != 8'd0 && raw[10:4] != 7'd0 && vel != 4'd0) begin
         if (phase_ff == 8'd1) note_sum = note_sum + {4'd0, rd_data[23:20]};
         else if (phase_ff == 8'd2) note_sum = note_sum + {4'd0, rd_data[19:16]};
      end
      note = note_sum[7] ? 7'd127 : note_sum[6:0];
      freq = (vel == 4'd0 || note == 7'd0) ? 11'd0 : nss_pkg::note_freq(note);
      lvl = nss_pkg::vel_level(vel, vol_c);
      case (voice_ff)
         2'd0: vchan = 3'd0;
         2'd1: vchan = 3'd1;
         default: vchan = 3'd3;
      endcase
      nxt_step = step_ff + 10'd1;
      for (int v = 0; v < 3; v++) begin
         arp_rearm[v] = (arp_enable_ff && arp_voice_ff == 2'(v)) ? nss_pkg::WORD_ARP
                                                                : nss_pkg::WORD_IDLE;
      end
   end

   // Multiplier operands and memory address
   always_comb begin
      mul_a = elapsed;
      mul_b = 10'd745;
      if (state_ff == S_PH1) begin
         mul_a = {16'd0, q_ff};
         mul_b = 10'd171;
      end else if (state_ff == S_ACHK || state_ff == S_VOICE) begin
         mul_a = {16'd0, rd_data[15:0]};
         mul_b = 10'd5;
      end
      rd_addr = (state_ff == S_ADV) ? step_in : step_ff;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      start_in = start_ff;
      running_in = running_ff;
      lastw_in = lastw_ff;
      now_in = now_ff;
      voice_in = voice_ff;
      adv_in = adv_ff;
      q_in = q_ff;
      phase_in = phase_ff;
      dur_in = dur_ff;
      pend_in = pend_ff;
      stopn_in = stopn_ff;
      cmd_in = cmd_ff;
      held_in = held_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in = req_now_tick;
               case (req_op)
                  nss_pkg::OP_START: begin
                     if (step_count_ff != 11'd0) begin
                        step_in = 10'd0;
                        start_in = req_now_tick;
                        running_in = 1'b1;
                        lastw_in = arp_rearm;
                     end
                  end
                  nss_pkg::OP_STOP: begin
                     running_in = 1'b0;
                     step_in = 10'd0;
                     stopn_in = 3'd0;
                     state_in = S_STOP;
                  end
                  nss_pkg::OP_UPDATE: begin
                     if (req_play_enable && running_ff) begin
                        if (vol_c == 3'd0) begin
                           running_in = 1'b0;
                           step_in = 10'd0;
                           stopn_in = 3'd0;
                           state_in = S_STOP;
                        end else begin
                           voice_in = 2'd0;
                           adv_in = 4'd0;
                           state_in = S_MUL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            q_in = mul_p[31:16];
            state_in = S_PH1;
         end
         S_PH1: begin
            phase_in = q_ff[7:0] - 8'(mul_p[16:9] * 2'd3);
            pend_in = 3'd0;
            state_in = S_VOICE;
         end
         S_VOICE: begin
            // one voice per cycle, stalls aside; step_ff's row stays on rd_data
            dur_in = mul_p[31:0];
            if ((is_arp ? nss_pkg::WORD_IDLE : raw) != lastw_ff[voice_ff]) begin
               // pass the held command on before holding the new one
               if (pend_ff == 3'd0 || !out_valid_ff || !rsp_stall) begin
                  if (pend_ff != 3'd0) begin
                     out_valid_in = 1'b1;
                     cmd_in = held_ff;
                  end
                  lastw_in[voice_ff] = raw;
                  held_in.channel = vchan;
                  held_in.on = freq != 11'd0;
                  held_in.freq = freq;
                  held_in.level = (freq == 11'd0) ? 4'd0 :
                                  (lvl == 3'd0) ? 4'd1 : {1'b0, lvl};
                  held_in.last = 1'b0;
                  pend_in = 3'd1;
                  voice_in = voice_ff + 2'd1;
                  if (voice_ff == 2'd2) state_in = S_EMIT;
               end
            end else begin
               voice_in = voice_ff + 2'd1;
               if (voice_ff == 2'd2) state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // send the held command as the last one of this transaction
            if (pend_ff == 3'd0) begin
               state_in = S_ACHK;
            end else if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               cmd_in = held_ff;
               cmd_in.last = 1'b1;
               pend_in = 3'd0;
               state_in = S_ACHK;
            end
         end
         S_ACHK: begin
            dur_in = mul_p[31:0];
            if (elapsed >= mul_p[31:0] && adv_ff != 4'(nss_pkg::MaxAdvance)) begin
               state_in = S_ADV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADV: begin
            start_in = start_ff + dur_ff;
            step_in = ({1'b0, nxt_step} >= step_count_ff || nxt_step == 10'd0)
                      ? 10'd0 : nxt_step;
            lastw_in = arp_rearm;
            adv_in = adv_ff + 4'd1;
            state_in = S_AREAD;
         end
         S_AREAD: begin
            state_in = S_ACHK;
         end
         S_STOP: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               cmd_in.on = 1'b0;
               cmd_in.freq = 11'd0;
               cmd_in.level = 4'd0;
               cmd_in.last = stopn_ff == 3'd3;
               case (stopn_ff)
                  3'd0: cmd_in.channel = 3'd0;
                  3'd1: cmd_in.channel = 3'd1;
                  3'd2: cmd_in.channel = 3'd3;
                  default: cmd_in.channel = 3'd5;
               endcase
               stopn_in = stopn_ff + 3'd1;
               if (stopn_ff == 3'd3) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 10'd0;
         start_ff <= 32'd0;
         running_ff <= 1'b0;
         for (int v = 0; v < 3; v++) lastw_ff[v] <= nss_pkg::WORD_IDLE;
         out_valid_ff <= 1'b0;
         voice_ff <= 2'd0;
         adv_ff <= 4'd0;
         pend_ff <= 3'd0;
         stopn_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         start_ff <= start_in;
         running_ff <= running_in;
         lastw_ff <= lastw_in;
         out_valid_ff <= out_valid_in;
         voice_ff <= voice_in;
         adv_ff <= adv_in;
         pend_ff <= pend_in;
         stopn_ff <= stopn_in;
      end
      now_ff <= now_in;
      q_ff <= q_in;
      phase_ff <= phase_in;
      dur_ff <= dur_in;
      cmd_ff <= cmd_in;
      held_ff <= held_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = out_valid_ff;
   assign rsp_sound_channel = cmd_ff.channel;
   assign rsp_channel_on = cmd_ff.on;
   assign rsp_frequency_code = cmd_ff.freq;
   assign rsp_level = cmd_ff.level;
   assign rsp_last = cmd_ff.last;
endmodule

// ===== rtl/nss_checker.sv =====
// Port checker for the note step sequencer, bound to the top level.
module nss_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_channel_on,
   input logic [10:0] rsp_frequency_code,
   input logic [3:0] rsp_level,
   input logic [2:0] rsp_sound_channel
);
   // Come out of reset idle with no result
   a_reset: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("busy after reset");
   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sound_channel))
      else $error("stalled result changed");
   // Silence carries no frequency or level
   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_channel_on |-> rsp_frequency_code == 11'd0 && rsp_level == 4'd0)
      else $error("silence with payload");
   // Playing command has a nonzero level and frequency
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_on |-> rsp_level != 4'd0 && rsp_frequency_code != 11'd0)
      else $error("play with zero level");
   // Channel is one of the mapped channels
   a_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sound_channel == 3'd0 || rsp_sound_channel == 3'd1 ||
                    rsp_sound_channel == 3'd3 || rsp_sound_channel == 3'd5)
      else $error("bad channel");
endmodule

bind note_step_sequencer_with_arpeggio nss_checker u_nss_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_channel_on(rsp_channel_on),
   .rsp_frequency_code(rsp_frequency_code), .rsp_level(rsp_level),
   .rsp_sound_channel(rsp_sound_channel)
);

// ===== verif/note_step_sequencer_with_arpeggio_tb.sv =====
// Self-checking testbench for the three-voice note step sequencer with arpeggio.
module note_step_sequencer_with_arpeggio_tb;

   localparam int CycleLimit = 600000;
   localparam int SettleCycles = 80;

   // One request transaction as driven on the req_ ports.
   typedef struct {
      logic [1:0] op;
      logic [9:0] idx;
      logic [15:0] mel;
      logic [15:0] bass;
      logic [15:0] chord;
      logic [7:0] arp;
      logic [15:0] ms;
      logic [31:0] tick;
      logic play;
      bit fixed;
   } seq_req_type;

   // Frequency codes for notes 40 to 111; every other note is silent.
   localparam logic [10:0] FreqOfNote [0:71] = '{
      11'h02C, 11'h09C, 11'h106, 11'h16B, 11'h1C9, 11'h223, 11'h277, 11'h2C6,
      11'h312, 11'h356, 11'h39B, 11'h3DA, 11'h416, 11'h44E, 11'h483, 11'h4B5,
      11'h4E5, 11'h511, 11'h53B, 11'h563, 11'h589, 11'h5AC, 11'h5CE, 11'h5ED,
      11'h60A, 11'h627, 11'h642, 11'h65B, 11'h672, 11'h689, 11'h69E, 11'h6B2,
      11'h6C4, 11'h6D6, 11'h6E7, 11'h6F7, 11'h706, 11'h714, 11'h721, 11'h72D,
      11'h739, 11'h744, 11'h74F, 11'h759, 11'h762, 11'h76B, 11'h773, 11'h77B,
      11'h783, 11'h78A, 11'h790, 11'h797, 11'h79D, 11'h7A2, 11'h7A7, 11'h7AC,
      11'h7B1, 11'h7B6, 11'h7BA, 11'h7BE, 11'h7C1, 11'h7C4, 11'h7C8, 11'h7CB,
      11'h7CE, 11'h7D1, 11'h7D4, 11'h7D6, 11'h7D9, 11'h7DB, 11'h7DD, 11'h7DF
   };

   // Level by velocity (row) and clamped volume (column).
   localparam logic [3:0] LevelOfVel [0:15][0:4] = '{
      '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0},
      '{0,0,0,0,1}, '{0,0,0,1,1}, '{0,0,0,1,1}, '{0,0,0,1,1},
      '{0,0,1,1,2}, '{0,0,1,1,2}, '{0,0,1,2,2}, '{0,0,1,2,2},
      '{0,0,1,2,3}, '{0,0,1,2,3}, '{0,0,1,2,3}, '{0,1,2,3,4}
   };
   localparam logic [2:0] VoiceChannel [0:2] = '{3'd0, 3'd1, 3'd3};

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_op = nss_pkg::OP_WRITE;
   logic [9:0] req_step_index = 0;
   logic [15:0] req_melody_word = 0;
   logic [15:0] req_bass_word = 0;
   logic [15:0] req_chord_word = 0;
   logic [7:0] req_arp_offsets = 0;
   logic [15:0] req_step_time_ms = 0;
   logic [31:0] req_now_tick = 0;
   logic req_play_enable = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_sound_channel;
   logic rsp_channel_on;
   logic [10:0] rsp_frequency_code;
   logic [3:0] rsp_level;
   logic rsp_last;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = nss_pkg::CSR_STEP_COUNT;
   logic [10:0] csr_write_data = 0;

   note_step_sequencer_with_arpeggio uut (.*);

   always #5 clock = ~clock;

   // Mirror of the sequencer state.
   logic [15:0] melody_mem [0:1023];
   logic [15:0] bass_mem [0:1023];
   logic [15:0] chord_mem [0:1023];
   logic [7:0] arp_mem [0:1023];
   logic [15:0] ms_mem [0:1023];
   int unsigned cur_step;
   logic [31:0] step_tick;
   bit playing;
   logic [15:0] prev_word [0:2];
   int unsigned step_count_q;
   bit arp_en_q;
   logic [1:0] arp_voice_q;
   logic [2:0] volume_q;

   nss_pkg::cmd_type pending_cmds [$];
   int unsigned mismatches = 0;
   int unsigned cmds_seen = 0;
   int unsigned reqs_sent = 0;
   int unsigned cycles = 0;
   int burst_left = 4;
   logic [31:0] now_q;

   // Queue one expected command.
   function automatic void push_cmd(logic [2:0] ch, logic on, logic [10:0] f, logic [3:0] lvl);
      nss_pkg::cmd_type c;
      c.channel = ch;
      c.on = on;
      c.freq = f;
      c.level = lvl;
      c.last = 1'b0;
      pending_cmds.push_back(c);
   endfunction

   function automatic void rearm_words();
      for (int v = 0; v < 3; v++)
         prev_word[v] = (arp_en_q && v == arp_voice_q) ? nss_pkg::WORD_ARP
                                                       : nss_pkg::WORD_IDLE;
   endfunction

   function automatic void silence_all();
      playing = 0;
      cur_step = 0;
      push_cmd(3'd0, 0, 0, 0);
      push_cmd(3'd1, 0, 0, 0);
      push_cmd(3'd3, 0, 0, 0);
      push_cmd(3'd5, 0, 0, 0);
   endfunction

   // Play the current step and consume elapsed steps.
   function automatic void play_step(logic [31:0] now);
      logic [2:0] vol;
      logic [31:0] elapsed, dur, prod, q, q3, ph;
      logic [15:0] raw, cmp;
      logic [3:0] vel, lvl;
      logic [10:0] f;
      int unsigned note, row, skips;
      vol = (volume_q > 3'd4) ? 3'd4 : volume_q;
      elapsed = now - step_tick;
      row = cur_step % 1024;
      if (vol == 0) begin
         silence_all();
         return;
      end
      for (int v = 0; v < 3; v++) begin
         raw = (v == 0) ? melody_mem[row] : (v == 1) ? bass_mem[row] : chord_mem[row];
         vel = raw[15:12];
         note = raw[10:4];
         cmp = raw;
         if (arp_en_q && v == arp_voice_q) begin
            if (arp_mem[row] != 0 && note > 0 && vel > 0) begin
               prod = elapsed * 32'd745;
               q = {16'd0, prod[31:16]};
               q3 = ((q * 32'd171) >> 9) & 32'hFF;
               ph = (q - q3 * 32'd3) & 32'hFF;
               if (ph == 1) note += arp_mem[row][7:4];
               else if (ph == 2) note += arp_mem[row][3:0];
               if (note > 127) note = 127;
            end
            cmp = nss_pkg::WORD_IDLE;
         end
         if (cmp != prev_word[v]) begin
            f = (vel == 0 || note < 40 || note > 111) ? 11'd0 : FreqOfNote[note - 40];
            if (f == 0) push_cmd(VoiceChannel[v], 0, 0, 0);
            else begin
               lvl = LevelOfVel[vel][vol];
               if (lvl == 0) lvl = 1;
               push_cmd(VoiceChannel[v], 1, f, lvl);
            end
            prev_word[v] = raw;
         end
      end
      dur = ms_mem[row] * 32'd5;
      skips = 0;
      while (elapsed >= dur) begin
         step_tick += dur;
         cur_step++;
         if (cur_step >= step_count_q || cur_step >= 1024) cur_step = 0;
         rearm_words();
         elapsed = now - step_tick;
         dur = ms_mem[cur_step % 1024] * 32'd5;
         if (++skips >= nss_pkg::MaxAdvance) break;
      end
   endfunction

   // Work out the commands caused by one accepted transaction.
   function automatic void predict_cmds(seq_req_type r);
      int unsigned n0;
      n0 = pending_cmds.size();
      case (r.op)
         nss_pkg::OP_WRITE: begin
            melody_mem[r.idx] = r.mel;
            bass_mem[r.idx] = r.bass;
            chord_mem[r.idx] = r.chord;
            arp_mem[r.idx] = r.arp;
            ms_mem[r.idx] = r.ms;
         end
         nss_pkg::OP_START: if (step_count_q != 0) begin
            cur_step = 0;
            rearm_words();
            step_tick = r.tick;
            playing = 1;
         end
         nss_pkg::OP_STOP: silence_all();
         default: if (r.play && playing) play_step(r.tick);
      endcase
      if (pending_cmds.size() > n0) pending_cmds[$].last = 1'b1;
   endfunction

   // Drive one transaction and hold it until accepted.
   task automatic send_req(seq_req_type r);
      int unsigned n0;
      nss_pkg::cmd_type typed [$];
      req_valid <= 1;
      req_op <= r.op;
      req_step_index <= r.idx;
      req_melody_word <= r.mel;
      req_bass_word <= r.bass;
      req_chord_word <= r.chord;
      req_arp_offsets <= r.arp;
      req_step_time_ms <= r.ms;
      req_now_tick <= r.tick;
      req_play_enable <= r.play;
      do @(posedge clock); while (req_stall);
      reqs_sent++;
      n0 = pending_cmds.size();
      predict_cmds(r);
      // Swap in hand-written expectations for fixed stop rows; other fixed rows expect none.
      if (r.fixed) begin
         while (pending_cmds.size() > n0) void'(pending_cmds.pop_back());
         if (r.op == nss_pkg::OP_STOP) begin
            typed = '{'{3'd0, 1'b0, 11'd0, 4'd0, 1'b0}, '{3'd1, 1'b0, 11'd0, 4'd0, 1'b0},
                      '{3'd3, 1'b0, 11'd0, 4'd0, 1'b0}, '{3'd5, 1'b0, 11'd0, 4'd0, 1'b1}};
            foreach (typed[k]) pending_cmds.push_back(typed[k]);
         end
      end
      // End the burst with a random gap.
      if (--burst_left <= 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
      end
   endtask

   // Wait until the block has drained and settled.
   task automatic drain();
      req_valid <= 0;
      while (pending_cmds.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [10:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         nss_pkg::CSR_STEP_COUNT: step_count_q = data;
         nss_pkg::CSR_ARP_ENABLE: arp_en_q = data[0];
         nss_pkg::CSR_ARP_VOICE: arp_voice_q = data[1:0];
         default: volume_q = data[2:0];
      endcase
   endtask

   function automatic seq_req_type make_req(logic [1:0] op, logic [9:0] idx,
         logic [15:0] mel, logic [15:0] bass, logic [15:0] chord, logic [7:0] arp,
         logic [15:0] ms, logic [31:0] tick, logic play, bit fixed);
      seq_req_type r;
      r = '{op, idx, mel, bass, chord, arp, ms, tick, play, fixed};
      return r;
   endfunction

   // Voice word from velocity and note.
   function automatic logic [15:0] vword(int vel, int note);
      return {vel[3:0], 1'b0, note[6:0], 4'($urandom_range(0, 15))};
   endfunction

   // Receiver: stall on a pattern redrawn at random among four modes.
   int stall_mode = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (reset) rsp_stall <= 0;
      else case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 1) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cycles % 8 < 3);
      endcase
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d commands outstanding", cycles,
            pending_cmds.size());
         $display("FAIL note_step_sequencer_with_arpeggio");
         $finish;
      end
   end

   // Check every accepted command against the oldest expectation.
   always @(posedge clock) begin
      nss_pkg::cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         cmds_seen++;
         if (pending_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected command ch=%0d on=%0d f=%h lvl=%0d last=%0d",
                  rsp_sound_channel, rsp_channel_on, rsp_frequency_code, rsp_level, rsp_last);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_sound_channel !== want.channel || rsp_channel_on !== want.on ||
                rsp_frequency_code !== want.freq || rsp_level !== want.level ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected ch=%0d on=%0d f=%h lvl=%0d last=%0d",
                     want.channel, want.on, want.freq, want.level, want.last);
                  $display("          got      ch=%0d on=%0d f=%h lvl=%0d last=%0d",
                     rsp_sound_channel, rsp_channel_on, rsp_frequency_code, rsp_level,
                     rsp_last);
               end
            end
         end
      end
   end

   localparam int PhaseCount = 8;
   localparam int StepsOf [0:PhaseCount-1] = '{1, 3, 8, 1024, 16, 5, 2, 4};
   localparam int VolOf [0:PhaseCount-1] = '{4, 3, 2, 1, 7, 0, 4, 3};

   initial begin
      seq_req_type rows [$];
      seq_req_type r;
      logic [31:0] t0;
      int written, roll;
      for (int v = 0; v < 3; v++) prev_word[v] = nss_pkg::WORD_IDLE;
      cur_step = 0;
      step_tick = 0;
      playing = 0;
      step_count_q = 0;
      arp_en_q = 0;
      arp_voice_q = 0;
      volume_q = 3;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: start with no steps, idle update, stop out of reset.
      rows.push_back(make_req(nss_pkg::OP_START, 0, 0, 0, 0, 0, 0, 32'h0000_0010, 1, 1));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, 32'h0000_0020, 1, 1));
      rows.push_back(make_req(nss_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      foreach (rows[i]) send_req(rows[i]);
      drain();
      write_reg(nss_pkg::CSR_STEP_COUNT, 11'd2);
      write_reg(nss_pkg::CSR_ARP_ENABLE, 11'd1);
      write_reg(nss_pkg::CSR_ARP_VOICE, 11'd0);
      write_reg(nss_pkg::CSR_MASTER_VOLUME, 11'd4);

      // Directed: extreme notes, saturating arpeggio, ROM holes, tick wrap.
      t0 = 32'hFFFF_FF80;
      rows = {};
      rows.push_back(make_req(nss_pkg::OP_WRITE, 0, 16'hF6F0, 16'h4280, 16'h03C0, 8'hF3,
         16'd60, 32'hFFFF_FFFF, 1, 0));
      rows.push_back(make_req(nss_pkg::OP_WRITE, 1, 16'h87F0, 16'hF000, 16'hFFFF, 8'hFF,
         16'hFFFF, 0, 0, 0));
      rows.push_back(make_req(nss_pkg::OP_WRITE, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
         16'hFFFF, 0, 1, 0));
      rows.push_back(make_req(nss_pkg::OP_START, 0, 0, 0, 0, 0, 0, t0, 0, 0));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0 + 5, 0, 0));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0 + 5, 1, 0));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0 + 90, 1, 0));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0 + 180, 1, 0));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0 + 290, 1, 0));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0 + 400, 1, 0));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0 + 32'h0100_0000,
         1, 0));
      rows.push_back(make_req(nss_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 1, 1));
      rows.push_back(make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, t0, 1, 1));
      foreach (rows[i]) send_req(rows[i]);

      // Random phases, each with its own register setting.
      for (int p = 0; p < PhaseCount; p++) begin
         drain();
         write_reg(nss_pkg::CSR_STEP_COUNT, 11'(StepsOf[p]));
         write_reg(nss_pkg::CSR_ARP_ENABLE, (p % 4 == 2) ? 11'd0 : 11'd1);
         write_reg(nss_pkg::CSR_ARP_VOICE, 11'(p % 4));
         write_reg(nss_pkg::CSR_MASTER_VOLUME, 11'(VolOf[p]));
         written = (StepsOf[p] > 16) ? 16 : StepsOf[p];
         now_q = $urandom;
         // Load the song, then start it.
         for (int s = 0; s < written; s++) begin
            roll = $urandom_range(0, 9);
            r = make_req(nss_pkg::OP_WRITE, 10'(s),
               vword($urandom_range(0, 15), $urandom_range(36, 115)),
               vword($urandom_range(0, 15), $urandom_range(36, 115)),
               vword($urandom_range(0, 15), $urandom_range(0, 127)),
               ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
               (roll == 0) ? 16'd0 : (roll == 1) ? 16'($urandom_range(0, 65535))
                  : 16'($urandom_range(1, 40)), $urandom, 1'($urandom_range(0, 1)), 0);
            if (roll == 2) r.mel = 16'($urandom_range(0, 65535));
            send_req(r);
         end
         send_req(make_req(nss_pkg::OP_START, 0, 0, 0, 0, 0, 0, now_q, 1, 0));
         for (int k = 0; k < 17; k++) begin
            roll = $urandom_range(0, 99);
            r = make_req(nss_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 1, 0);
            now_q += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 300);
            r.tick = now_q;
            if (roll < 8) r.op = nss_pkg::OP_START;
            else if (roll < 12) r.op = nss_pkg::OP_STOP;
            else if (roll < 22) begin
               r = make_req(nss_pkg::OP_WRITE, 10'($urandom_range(0, written - 1)),
                  16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                  16'($urandom_range(0, 60)), $urandom, 1'($urandom), 0);
            end else if (roll < 30) r.play = 0;
            // Keep playback inside the loaded steps of a long song.
            if (r.op == nss_pkg::OP_UPDATE && step_count_q > written &&
                cur_step + nss_pkg::MaxAdvance >= written)
               r.op = nss_pkg::OP_START;
            if (p == 3 && k == 10) begin
               drain();
               burst_left = 40;
            end
            send_req(r);
         end
      end

      drain();
      $display("covered %0d request transactions and %0d commands over %0d register settings",
         reqs_sent, cmds_seen, PhaseCount + 1);
      $display("mismatches: %0d, commands still expected: %0d", mismatches,
         pending_cmds.size());
      if (mismatches == 0 && pending_cmds.size() == 0)
         $display("PASS note_step_sequencer_with_arpeggio");
      else
         $display("FAIL note_step_sequencer_with_arpeggio");
      $finish;
   end

endmodule
